### design/cpf_pkg.sv
// shared types, frame constants and crc byte-update functions for the command framer
`default_nettype none

package cpf_pkg;

  // one motor command as accepted
  typedef struct packed {
    logic [7:0]  axis;
    logic [31:0] torque_bits;
  } cpf_cmd_t;

  // one frame byte as delivered
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } cpf_result_t;

  // a command with its finished checksums, waiting for the emitter
  typedef struct packed {
    cpf_cmd_t    cmd;
    logic [7:0]  crc8;
    logic [15:0] crc16;
  } cpf_job_t;

  localparam logic [7:0]  SyncByte   = 8'hAA;
  localparam logic [7:0]  PayloadLen = 8'd5;
  localparam logic [7:0]  Crc8Poly   = 8'h37;
  localparam logic [7:0]  Crc8Init   = 8'h42;
  localparam logic [15:0] Crc16Poly  = 16'h3D65;
  localparam logic [15:0] Crc16Init  = 16'h1337;

  // crc-8 over one byte, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ Crc8Poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // crc-16 over one byte, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ Crc16Poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### design/cpf_front.sv
// front end: takes a command and runs both checksums over its payload, one byte a cycle; full queue stalls the last
`default_nettype none

module cpf_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  cpf_pkg::cpf_cmd_t     cmd_i,
  output logic                  busy,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output cpf_pkg::cpf_job_t     job_o
);
  import cpf_pkg::*;

  localparam logic [2:0] LastIdx = 3'd4;

  logic        active_q, active_d;
  logic [2:0]  idx_q, idx_d;
  cpf_cmd_t    cmd_q;
  logic [7:0]  crc8_q, crc8_d, crc8_nx;
  logic [15:0] crc16_q, crc16_d, crc16_nx;
  logic [7:0]  cur_byte;
  logic        accept, stall;

  assign busy   = active_q;
  assign accept = start && !active_q;
  assign stall  = (idx_q == LastIdx) && q_full_i;

  // payload byte for this step: axis, then torque low byte first
  always_comb begin
    case (idx_q)
      3'd0:    cur_byte = cmd_q.axis;
      3'd1:    cur_byte = cmd_q.torque_bits[7:0];
      3'd2:    cur_byte = cmd_q.torque_bits[15:8];
      3'd3:    cur_byte = cmd_q.torque_bits[23:16];
      3'd4:    cur_byte = cmd_q.torque_bits[31:24];
      default: cur_byte = cmd_q.axis;
    endcase
  end

  assign crc8_nx  = crc8_byte(crc8_q, cur_byte);
  assign crc16_nx = crc16_byte(crc16_q, cur_byte);

  // hand the finished job to the queue in the cycle that folds in the last payload byte, once the queue is not full
  assign push_o          = active_q && (idx_q == LastIdx) && !q_full_i;
  assign job_o.cmd       = cmd_q;
  assign job_o.crc8      = crc8_nx;
  assign job_o.crc16     = crc16_nx;

  // step control
  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    crc8_d   = crc8_q;
    crc16_d  = crc16_q;
    if (accept) begin
      active_d = 1'b1;
      idx_d    = '0;
      crc8_d   = Crc8Init;
      crc16_d  = Crc16Init;
    end else if (active_q && !stall) begin
      crc8_d  = crc8_nx;
      crc16_d = crc16_nx;
      if (idx_q == LastIdx) begin
        active_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
    end
  end

  // payload and checksum registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    crc8_q  <= crc8_d;
    crc16_q <= crc16_d;
  end

endmodule

`default_nettype wire

### design/cpf_queue.sv
// short job queue between the checksum front end and the byte emitter
`default_nettype none

module cpf_queue #(
  parameter int Depth = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  cpf_pkg::cpf_job_t push_job_i,
  input  wire logic         pop_i,
  output cpf_pkg::cpf_job_t head_o,
  output logic              full_o,
  output logic              empty_o
);
  import cpf_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastSlot = AW'(Depth - 1);

  cpf_job_t        entries_q [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entries_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // job storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

### design/cpf_back.sv
// back end: walks the head job through the ten frame bytes, one registered byte a cycle while a job is queued
`default_nettype none

module cpf_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  cpf_pkg::cpf_job_t  head_i,
  input  wire logic          q_empty_i,
  output logic               pop_o,
  output logic               valid_o,
  output cpf_pkg::cpf_result_t result_o
);
  import cpf_pkg::*;

  localparam logic [3:0] PosSync  = 4'd0;
  localparam logic [3:0] PosLen   = 4'd1;
  localparam logic [3:0] PosCrc8  = 4'd2;
  localparam logic [3:0] PosAxis  = 4'd3;
  localparam logic [3:0] PosT0    = 4'd4;
  localparam logic [3:0] PosT1    = 4'd5;
  localparam logic [3:0] PosT2    = 4'd6;
  localparam logic [3:0] PosT3    = 4'd7;
  localparam logic [3:0] PosCrcLo = 4'd8;
  localparam logic [3:0] PosCrcHi = 4'd9;

  logic [3:0]  pos_q, pos_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic        emit;

  assign emit  = !q_empty_i;
  assign pop_o = emit && (pos_q == PosCrcHi);

  // byte select for the current frame position
  always_comb begin
    case (pos_q)
      PosSync:  byte_d = SyncByte;
      PosLen:   byte_d = PayloadLen;
      PosCrc8:  byte_d = head_i.crc8;
      PosAxis:  byte_d = head_i.cmd.axis;
      PosT0:    byte_d = head_i.cmd.torque_bits[7:0];
      PosT1:    byte_d = head_i.cmd.torque_bits[15:8];
      PosT2:    byte_d = head_i.cmd.torque_bits[23:16];
      PosT3:    byte_d = head_i.cmd.torque_bits[31:24];
      PosCrcLo: byte_d = head_i.crc16[7:0];
      PosCrcHi: byte_d = head_i.crc16[15:8];
      default:  byte_d = SyncByte;
    endcase
  end

  // position counter and strobe
  always_comb begin
    valid_d = emit;
    last_d  = (pos_q == PosCrcHi);
    pos_d   = pos_q;
    if (emit) begin
      pos_d = (pos_q == PosCrcHi) ? PosSync : pos_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosSync;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  // output byte registers
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign valid_o             = valid_q;
  assign result_o.frame_byte = byte_q;
  assign result_o.last_byte  = last_q;

endmodule

`default_nettype wire

### design/crc_protected_command_framer_unit.sv
// top level of the crc protected command framer: front end, job queue, byte emitter
//
//  channel   | ports                    | handshake
//  ----------+--------------------------+-----------------------------------------
//  command   | start, cmd_i, busy       | taken at an edge with start high, busy low
//  frame     | valid_o, result_o        | one byte per valid_o cycle, no back-pressure
//
// each command produces ten frame bytes on consecutive cycles; the emitter, not the
// front end, sets the sustained command rate. the front end runs the checksums one
// payload byte a cycle and holds busy high during that time, and longer if the
// queue is full. when the queue is empty, the first byte follows the checksum
// steps, the queue write and the emitter's output register.
// reset clears all control state; nothing needs a clearing pass.
`default_nettype none

module crc_protected_command_framer_unit #(
  parameter int QueueDepth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  cpf_pkg::cpf_cmd_t    cmd_i,
  output logic                 busy,
  output logic                 valid_o,
  output cpf_pkg::cpf_result_t result_o
);
  import cpf_pkg::*;

  logic     q_full, q_empty, push, pop;
  cpf_job_t push_job, head_job;

  // checksum front end
  cpf_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .busy     (busy),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  // job queue
  cpf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // frame byte emitter
  cpf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head_job),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .valid_o   (valid_o),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire

### design/cpf_checker.sv
// port-level checker for the command framer and its bind
`default_nettype none

module cpf_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            start,
  input wire logic            busy,
  input wire logic            valid_o,
  input cpf_pkg::cpf_result_t result_o
);
  import cpf_pkg::*;

  // an accepted command keeps the front end busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted item");

  // a frame opens with the sync byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !$past(valid_o) |-> result_o.frame_byte == SyncByte)
    else $error("frame does not start with sync");

  // a new frame directly after a last byte also opens with sync
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.last_byte |=> !valid_o || result_o.frame_byte == SyncByte)
    else $error("back-to-back frame without sync");

  // the last byte has a strobed byte at the place where its frame's first byte belongs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.last_byte |-> $past(valid_o, 9))
    else $error("frame shorter than ten bytes");

endmodule

bind crc_protected_command_framer_unit cpf_checker u_cpf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .valid_o  (valid_o),
  .result_o (result_o)
);

`default_nettype wire
